### design/keyed_ordered_table_core_defines.svh
// Assertion macros shared by the keyed ordered table design.
// Expects clk and arst_n in the scope of each use.
`ifndef KEYED_ORDERED_TABLE_CORE_DEFINES_SVH
`define KEYED_ORDERED_TABLE_CORE_DEFINES_SVH

// same-cycle implication
`define KOT_ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("keyed table check failed");

// next-cycle implication
`define KOT_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("keyed table sequence check failed");

`endif

### design/kot_pkg.sv
// Package for the keyed ordered table: sizes, request and status codes,
// interface structs and the ring address helper. No dependencies.
`timescale 1ns / 1ps

package kot_pkg;

	localparam int ENTRIES = 16;
	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W = $clog2(ENTRIES + 1);

	localparam int KEY_W = 32;
	localparam int VAL_W = 32;
	localparam int IN_TDATA_W = KEY_W + VAL_W;
	localparam int OUT_W = 1 + VAL_W + 2 + CNT_W;
	localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

	localparam logic [1:0] REQ_LOOKUP = 2'd0;
	localparam logic [1:0] REQ_UPSERT = 2'd1;
	localparam logic [1:0] REQ_INSERT = 2'd2;
	localparam logic [1:0] REQ_REMOVE = 2'd3;

	localparam logic [1:0] STAT_DONE = 2'd0;
	localparam logic [1:0] STAT_MISSING = 2'd1;
	localparam logic [1:0] STAT_FULL = 2'd2;

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [CNT_W-1:0] cnt_t;

	typedef struct packed {
		logic rd_en;
		idx_t rd_addr;
		logic wr_en;
		idx_t wr_addr;
		logic signed [KEY_W-1:0] wr_key;
		logic [VAL_W-1:0] wr_val;
	} mem_req_t;

	typedef struct packed {
		logic signed [KEY_W-1:0] key;
		logic [VAL_W-1:0] val;
	} mem_rd_t;

	typedef struct packed {
		cnt_t count;
		logic [1:0] status;
		logic [VAL_W-1:0] value;
		logic found;
	} res_t;

	// physical slot of logical position idx in the ring that starts at head
	function automatic idx_t phys_addr(input idx_t head, input idx_t idx);
		logic [IDX_W:0] s;
		s = {1'b0, head} + {1'b0, idx};
		if (s >= (IDX_W + 1)'(ENTRIES)) begin
			s = s - (IDX_W + 1)'(ENTRIES);
		end
		return s[IDX_W-1:0];
	endfunction

endpackage

### design/kot_store.sv
// Key and value storage of the keyed ordered table: one write port and one
// read port with registered read data. Depends on kot_pkg.
`timescale 1ns / 1ps

module kot_store (
	input  logic              clk,
	input  kot_pkg::mem_req_t mem_req,
	output kot_pkg::mem_rd_t  rd_data
);
	import kot_pkg::*;

	logic signed [KEY_W-1:0] key_mem [ENTRIES];
	logic [VAL_W-1:0] val_mem [ENTRIES];

	always_ff @(posedge clk) begin
		if (mem_req.wr_en) begin
			key_mem[mem_req.wr_addr] <= mem_req.wr_key;
			val_mem[mem_req.wr_addr] <= mem_req.wr_val;
		end
		if (mem_req.rd_en) begin
			rd_data.key <= key_mem[mem_req.rd_addr];
			rd_data.val <= val_mem[mem_req.rd_addr];
		end
	end

endmodule

### design/kot_ctrl.sv
// Sequencer of the keyed ordered table: key scan through the shared read
// port and compare, front insert, in-place update and compaction on remove.
// Depends on kot_pkg and keyed_ordered_table_core_defines.svh.
`timescale 1ns / 1ps
`include "keyed_ordered_table_core_defines.svh"

module kot_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic [1:0]                    in_type,
	input  logic signed [kot_pkg::KEY_W-1:0] in_key,
	input  logic [kot_pkg::VAL_W-1:0]     in_val,
	output logic                          res_valid,
	input  logic                          res_ready,
	output kot_pkg::res_t                 res,
	output kot_pkg::mem_req_t             mem_req,
	input  kot_pkg::mem_rd_t              rd_data
);
	import kot_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_SCAN = 3'd1;
	localparam logic [2:0] S_DECIDE = 3'd2;
	localparam logic [2:0] S_SHIFT = 3'd3;
	localparam logic [2:0] S_DONE = 3'd4;

	logic [2:0] state_q;
	cnt_t fill_q;
	idx_t head_q;
	cnt_t rd_idx_q;
	logic cmp_vld_q;

	logic [1:0] type_q;
	logic signed [KEY_W-1:0] key_q;
	logic [VAL_W-1:0] val_q;
	logic hit_q;
	idx_t slot_q;
	idx_t cmp_idx_q;
	logic [VAL_W-1:0] vout_q;
	logic [1:0] status_q;

	idx_t rd_lidx;
	idx_t head_dec;
	logic rd_more;
	logic key_hit;
	logic cmp_last;
	logic needs_push;
	logic full;

	always_comb begin
		rd_lidx = rd_idx_q[IDX_W-1:0];
		rd_more = rd_idx_q < fill_q;
		head_dec = (head_q == '0) ? IDX_W'(ENTRIES - 1) : head_q - 1'b1;
		key_hit = cmp_vld_q && (rd_data.key == key_q);
		cmp_last = cmp_vld_q && ((CNT_W'(cmp_idx_q) + CNT_W'(1)) == fill_q);
		needs_push = (type_q == REQ_INSERT) || ((type_q == REQ_UPSERT) && !hit_q);
		full = fill_q == CNT_W'(ENTRIES);
		in_ready = state_q == S_IDLE;
		res_valid = state_q == S_DONE;
		res.found = hit_q;
		res.value = vout_q;
		res.status = status_q;
		res.count = fill_q;

		mem_req = '0;
		unique case (state_q)
			S_SCAN: begin
				mem_req.rd_en = rd_more;
				mem_req.rd_addr = phys_addr(head_q, rd_lidx);
			end
			S_DECIDE: begin
				if ((type_q == REQ_UPSERT) && hit_q) begin
					mem_req.wr_en = 1'b1;
					mem_req.wr_addr = phys_addr(head_q, slot_q);
				end else if (needs_push && !full) begin
					mem_req.wr_en = 1'b1;
					mem_req.wr_addr = head_dec;
				end
				mem_req.wr_key = key_q;
				mem_req.wr_val = val_q;
			end
			S_SHIFT: begin
				mem_req.rd_en = rd_more;
				mem_req.rd_addr = phys_addr(head_q, rd_lidx);
				// entry read last cycle moves up one slot
				mem_req.wr_en = cmp_vld_q;
				mem_req.wr_addr = phys_addr(head_q, cmp_idx_q - 1'b1);
				mem_req.wr_key = rd_data.key;
				mem_req.wr_val = rd_data.val;
			end
			S_IDLE, S_DONE: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			fill_q <= '0;
			head_q <= '0;
			rd_idx_q <= '0;
			cmp_vld_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						rd_idx_q <= '0;
						cmp_vld_q <= 1'b0;
						state_q <= (fill_q == '0) ? S_DECIDE : S_SCAN;
					end
				end
				S_SCAN: begin
					if (rd_more) begin
						rd_idx_q <= rd_idx_q + 1'b1;
					end
					cmp_vld_q <= rd_more;
					if (key_hit || cmp_last) begin
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					state_q <= S_DONE;
					if ((type_q == REQ_REMOVE) && hit_q) begin
						rd_idx_q <= CNT_W'(slot_q) + CNT_W'(1);
						cmp_vld_q <= 1'b0;
						state_q <= S_SHIFT;
					end else if ((type_q != REQ_LOOKUP) && (type_q != REQ_REMOVE)
							&& needs_push && !full) begin
						fill_q <= fill_q + 1'b1;
						head_q <= head_dec;
					end
				end
				S_SHIFT: begin
					if (rd_more) begin
						rd_idx_q <= rd_idx_q + 1'b1;
					end
					cmp_vld_q <= rd_more;
					if (!rd_more && !cmp_vld_q) begin
						fill_q <= fill_q - 1'b1;
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					type_q <= in_type;
					key_q <= in_key;
					val_q <= in_val;
					hit_q <= 1'b0;
					vout_q <= '0;
				end
			end
			S_SCAN: begin
				if (rd_more) begin
					cmp_idx_q <= rd_lidx;
				end
				if (key_hit) begin
					hit_q <= 1'b1;
					slot_q <= cmp_idx_q;
					vout_q <= rd_data.val;
				end
			end
			S_DECIDE: begin
				unique case (type_q)
					REQ_LOOKUP: status_q <= hit_q ? STAT_DONE : STAT_MISSING;
					REQ_UPSERT: status_q <= (!hit_q && full) ? STAT_FULL : STAT_DONE;
					REQ_INSERT: status_q <= full ? STAT_FULL : STAT_DONE;
					REQ_REMOVE: status_q <= hit_q ? STAT_DONE : STAT_MISSING;
					default: status_q <= STAT_DONE;
				endcase
				if (type_q != REQ_LOOKUP) begin
					vout_q <= '0;
				end
			end
			S_SHIFT: begin
				if (rd_more) begin
					cmp_idx_q <= rd_lidx;
				end
			end
			S_DONE: begin
			end
			default: begin
			end
		endcase
	end

	`KOT_ASSERT_IMPL(a_fill_bound, 1'b1, fill_q <= CNT_W'(ENTRIES))
	`KOT_ASSERT_IMPL(a_scan_no_write, state_q == S_SCAN, !mem_req.wr_en)
	`KOT_ASSERT_IMPL(a_port_no_clash, mem_req.wr_en && mem_req.rd_en,
		mem_req.wr_addr != mem_req.rd_addr)
	`KOT_ASSERT_NEXT(a_done_hold, state_q == S_DONE && !res_ready,
		state_q == S_DONE && $stable(res))

endmodule

### design/keyed_ordered_table_core.sv
// Top level of the keyed ordered table: stream ports, sequencer, storage and
// the result register. Depends on kot_pkg, kot_ctrl and kot_store.
`timescale 1ns / 1ps

// Bounded key/value table kept newest first in a ring of ENTRIES slots, one
// request per transaction with exactly one result each. A request walks the
// stored keys through the single registered read port and one compare:
// acceptance, then a scan that stops at the newest match or after the oldest
// entry (skipped on an empty table), a step to decide and write, and a step to
// hand over the result; a remove then compacts the entries behind the removed
// one at one slot per cycle.
// s_tready is high only between requests; the result register lets the next
// request start while the previous result waits.
module keyed_ordered_table_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// [31:0] req_key (signed), [63:32] req_value
	input  logic [kot_pkg::IN_TDATA_W-1:0]    s_tdata,
	// [1:0] req_type
	input  logic [1:0]                        s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// [0] found, [32:1] value_out, [34:33] status, [39:35] entry_count
	output logic [kot_pkg::OUT_TDATA_W-1:0]   m_tdata
);
	import kot_pkg::*;

	mem_req_t mem_req;
	mem_rd_t rd_data;
	res_t res;
	logic res_valid;
	logic res_ready;

	logic out_valid_q;
	res_t out_res_q;

	assign res_ready = !out_valid_q || m_tready;

	kot_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_type   (s_tuser),
		.in_key    (s_tdata[KEY_W-1:0]),
		.in_val    (s_tdata[KEY_W+VAL_W-1:KEY_W]),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.mem_req   (mem_req),
		.rd_data   (rd_data)
	);

	kot_store u_store (
		.clk     (clk),
		.mem_req (mem_req),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_res_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata = OUT_TDATA_W'(out_res_q);

endmodule
